### src/octree_box_placement_macros.svh
// Assertion macros for the octree box placement block.
// Included by files that carry concurrent checks; needs no package.
`ifndef OCTREE_BOX_PLACEMENT_MACROS_SVH
`define OCTREE_BOX_PLACEMENT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define OBP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define OBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/obp_pkg.sv
// Shared types and constants for the octree box placement block.
// No dependencies; used by the channel interfaces, the level stage and the top level.
package obp_pkg;

    // Field widths of the channels
    localparam int unsigned COORD_W   = 24;
    localparam int unsigned DEPTH_W   = 4;
    localparam int unsigned SIZE_W    = 5;
    localparam int unsigned LEVEL_W   = 4;
    localparam int unsigned CELL_W    = 8;
    localparam int unsigned CFG_IDX_W = 3;

    // Default and largest supported number of levels
    localparam int unsigned MAX_LEVELS_DEF = 8;
    localparam int unsigned MAX_LEVELS_TOP = 16;

    // Internal widths: level count up to the top, index bits one per level,
    // centre wide enough for root plus offsets at any size_log2 code
    localparam int unsigned LVL_W = 5;
    localparam int unsigned IDX_W = MAX_LEVELS_TOP;
    localparam int unsigned CTR_W = 33;

    // Register reset values
    localparam logic [DEPTH_W-1:0] MAX_DEPTH_RST = 4'd4;
    localparam logic [SIZE_W-1:0]  SIZE_LOG2_RST = 5'd16;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [CTR_W-1:0]   t_ctr;
    typedef logic [LVL_W-1:0]          t_lvl;
    typedef logic [IDX_W-1:0]          t_idx;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_DEPTH = 3'd0,
        CFG_ROOT_CX   = 3'd1,
        CFG_ROOT_CY   = 3'd2,
        CFG_ROOT_CZ   = 3'd3,
        CFG_SIZE_LOG2 = 3'd4
    } t_cfg_idx;

    // One box on its way down the levels
    typedef struct packed {
        logic   live;
        t_lvl   level;
        t_idx   idx_x;
        t_idx   idx_y;
        t_idx   idx_z;
        t_ctr   ctr_x;
        t_ctr   ctr_y;
        t_ctr   ctr_z;
        t_coord min_x;
        t_coord min_y;
        t_coord min_z;
        t_coord max_x;
        t_coord max_y;
        t_coord max_z;
    } t_item;

    // Settings every level stage sees
    typedef struct packed {
        t_lvl              depth;
        logic [SIZE_W-1:0] size_log2;
    } t_ctrl;

    // Sign-extend a coordinate to centre width
    function automatic t_ctr sext(input t_coord v);
        return {{(CTR_W - COORD_W){v[COORD_W-1]}}, v};
    endfunction

endpackage

### src/obp_if.sv
// Channel interfaces of the octree box placement block: box in, node out, register writes.
// Depends on obp_pkg for field widths.
interface obp_box_if;
    logic                  valid;
    logic                  ready;
    obp_pkg::t_coord       box_min_x;
    obp_pkg::t_coord       box_min_y;
    obp_pkg::t_coord       box_min_z;
    obp_pkg::t_coord       box_max_x;
    obp_pkg::t_coord       box_max_y;
    obp_pkg::t_coord       box_max_z;

    modport source (output valid, box_min_x, box_min_y, box_min_z,
                    box_max_x, box_max_y, box_max_z, input ready);
    modport sink   (input valid, box_min_x, box_min_y, box_min_z,
                    box_max_x, box_max_y, box_max_z, output ready);
endinterface

interface obp_node_if;
    logic                          valid;
    logic                          ready;
    logic [obp_pkg::LEVEL_W-1:0]   node_level;
    logic [obp_pkg::CELL_W-1:0]    cell_x;
    logic [obp_pkg::CELL_W-1:0]    cell_y;
    logic [obp_pkg::CELL_W-1:0]    cell_z;

    modport source (output valid, node_level, cell_x, cell_y, cell_z, input ready);
    modport sink   (input valid, node_level, cell_x, cell_y, cell_z, output ready);
endinterface

interface obp_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [obp_pkg::CFG_IDX_W-1:0]  index;
    logic [obp_pkg::COORD_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### src/obp_stage.sv
// One octree level: compares the box with the cell centre and steps into a child.
// Depends on obp_pkg for the item and control structs.
module obp_stage #(
    parameter int unsigned LEVEL = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  obp_pkg::t_item i_item,
    input  obp_pkg::t_ctrl i_ctrl,
    output logic           o_valid,
    output obp_pkg::t_item o_item
);

    localparam obp_pkg::t_lvl HERE = obp_pkg::t_lvl'(LEVEL);

    logic           r_valid;
    obp_pkg::t_item r_item;
    obp_pkg::t_item n_item;
    logic           w_xlo, w_xhi, w_ylo, w_yhi, w_zlo, w_zhi;
    logic           w_gx, w_gy, w_gz;
    logic           w_step;
    logic           w_split;
    logic signed [6:0] w_sh;
    obp_pkg::t_ctr  w_off;

    // Compare box against the centre on each axis
    always_comb begin
        w_xlo = obp_pkg::sext(i_item.min_x) < i_item.ctr_x;
        w_xhi = obp_pkg::sext(i_item.max_x) > i_item.ctr_x;
        w_ylo = obp_pkg::sext(i_item.min_y) < i_item.ctr_y;
        w_yhi = obp_pkg::sext(i_item.max_y) > i_item.ctr_y;
        w_zlo = obp_pkg::sext(i_item.min_z) < i_item.ctr_z;
        w_zhi = obp_pkg::sext(i_item.max_z) > i_item.ctr_z;
        w_split = (w_xlo && w_xhi) || (w_ylo && w_yhi) || (w_zlo && w_zhi);
        w_gx = !w_xlo;
        w_gy = w_yhi;
        w_gz = !w_zlo;
    end

    // Child offset: half of the child side, zero once below one LSB
    always_comb begin
        w_sh  = $signed(7'(i_ctrl.size_log2)) - $signed(7'(LEVEL + 2));
        w_off = w_sh[6] ? '0 : (obp_pkg::t_ctr'(1) << w_sh[4:0]);
    end

    // Advance one level, or freeze the item where it stopped
    always_comb begin
        n_item = i_item;
        w_step = i_item.live && (HERE < i_ctrl.depth);
        if (w_step && !w_split) begin
            n_item.ctr_x = w_gx ? i_item.ctr_x + w_off : i_item.ctr_x - w_off;
            n_item.ctr_y = w_gy ? i_item.ctr_y + w_off : i_item.ctr_y - w_off;
            n_item.ctr_z = w_gz ? i_item.ctr_z + w_off : i_item.ctr_z - w_off;
            n_item.idx_x = {i_item.idx_x[obp_pkg::IDX_W-2:0], w_gx};
            n_item.idx_y = {i_item.idx_y[obp_pkg::IDX_W-2:0], w_gy};
            n_item.idx_z = {i_item.idx_z[obp_pkg::IDX_W-2:0], w_gz};
            n_item.level = i_item.level + obp_pkg::t_lvl'(1);
        end else begin
            n_item.live = 1'b0;
        end
    end

    // Hold on stall, move on enable
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### src/octree_box_placement.sv
// Top level of the octree box placement block: registers, input stage, level pipeline.
// Depends on obp_pkg, the channel interfaces in obp_if.sv, obp_stage and the macro header.
//
// Usage:
//   i_box carries one axis-aligned box (min and max corners, signed 24-bit,
//   8 fraction bits). o_node returns the deepest octree cell, up to max_depth,
//   that holds the box whole: its level and x, y, z cell indexes.
//   i_cfg writes the five registers by index (max_depth, root centre x, y, z,
//   size_log2); it is always ready, and writes are meant for an idle block.
//   Each box gives exactly one word on o_node, in order.
// Pipeline:
//   One input register and one register stage per octree level, MAX_LEVELS of
//   them, the last one being the output register; a box passes the input register
//   and each level stage in turn. One box enters per cycle unless o_node stalls.
// Reset: synchronous, active low; clears all valid bits and loads the register
//   defaults (max_depth 4, centre at the origin, size_log2 16).
// Stall: while o_node holds a word that is not taken, the whole pipeline holds
//   and i_box.ready is low; nothing is dropped or repeated.
`include "octree_box_placement_macros.svh"

module octree_box_placement #(
    parameter int unsigned MAX_LEVELS = obp_pkg::MAX_LEVELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    obp_box_if.sink     i_box,
    obp_cfg_if.sink     i_cfg,
    obp_node_if.source  o_node
);

    // Configuration registers
    logic [obp_pkg::DEPTH_W-1:0] r_max_depth;
    obp_pkg::t_coord             r_root_cx;
    obp_pkg::t_coord             r_root_cy;
    obp_pkg::t_coord             r_root_cz;
    logic [obp_pkg::SIZE_W-1:0]  r_size_log2;

    logic           w_en;
    obp_pkg::t_ctrl w_ctrl;
    obp_pkg::t_item n_in_item;
    logic           w_valid [0:MAX_LEVELS];
    obp_pkg::t_item w_item  [0:MAX_LEVELS];
    logic           r_in_valid;
    obp_pkg::t_item r_in_item;

    // Write registers by index
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_depth <= obp_pkg::MAX_DEPTH_RST;
            r_root_cx   <= '0;
            r_root_cy   <= '0;
            r_root_cz   <= '0;
            r_size_log2 <= obp_pkg::SIZE_LOG2_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                obp_pkg::CFG_MAX_DEPTH: r_max_depth <= i_cfg.data[obp_pkg::DEPTH_W-1:0];
                obp_pkg::CFG_ROOT_CX:   r_root_cx   <= i_cfg.data;
                obp_pkg::CFG_ROOT_CY:   r_root_cy   <= i_cfg.data;
                obp_pkg::CFG_ROOT_CZ:   r_root_cz   <= i_cfg.data;
                obp_pkg::CFG_SIZE_LOG2: r_size_log2 <= i_cfg.data[obp_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Saturate the depth to the number of level stages
    always_comb begin
        if (obp_pkg::t_lvl'(r_max_depth) > obp_pkg::t_lvl'(MAX_LEVELS)) begin
            w_ctrl.depth = obp_pkg::t_lvl'(MAX_LEVELS);
        end else begin
            w_ctrl.depth = obp_pkg::t_lvl'(r_max_depth);
        end
        w_ctrl.size_log2 = r_size_log2;
    end

    // Global advance: move whenever the output word is empty or taken
    assign w_en        = !w_valid[MAX_LEVELS] || o_node.ready;
    assign i_box.ready = w_en;

    // Start every box at the root cell
    always_comb begin
        n_in_item.live  = 1'b1;
        n_in_item.level = '0;
        n_in_item.idx_x = '0;
        n_in_item.idx_y = '0;
        n_in_item.idx_z = '0;
        n_in_item.ctr_x = obp_pkg::sext(r_root_cx);
        n_in_item.ctr_y = obp_pkg::sext(r_root_cy);
        n_in_item.ctr_z = obp_pkg::sext(r_root_cz);
        n_in_item.min_x = i_box.box_min_x;
        n_in_item.min_y = i_box.box_min_y;
        n_in_item.min_z = i_box.box_min_z;
        n_in_item.max_x = i_box.box_max_x;
        n_in_item.max_y = i_box.box_max_y;
        n_in_item.max_z = i_box.box_max_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_en) begin
            r_in_valid <= i_box.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in_item <= n_in_item;
        end
    end

    assign w_valid[0] = r_in_valid;
    assign w_item[0]  = r_in_item;

    // One stage per octree level
    for (genvar g = 0; g < MAX_LEVELS; g++) begin : g_level
        obp_stage #(
            .LEVEL (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[g]),
            .i_item  (w_item[g]),
            .i_ctrl  (w_ctrl),
            .o_valid (w_valid[g+1]),
            .o_item  (w_item[g+1])
        );
    end

    // Drive the result word from the last stage
    assign o_node.valid      = w_valid[MAX_LEVELS];
    assign o_node.node_level = w_item[MAX_LEVELS].level[obp_pkg::LEVEL_W-1:0];
    assign o_node.cell_x     = w_item[MAX_LEVELS].idx_x[obp_pkg::CELL_W-1:0];
    assign o_node.cell_y     = w_item[MAX_LEVELS].idx_y[obp_pkg::CELL_W-1:0];
    assign o_node.cell_z     = w_item[MAX_LEVELS].idx_z[obp_pkg::CELL_W-1:0];

    // Checks
    `OBP_ASSERT_NEXT(a_take_box, i_clk, i_rst_n, i_box.valid && i_box.ready, w_valid[0], "accepted box not captured")
    `OBP_ASSERT_NOW(a_stall_in, i_clk, i_rst_n, o_node.valid && !o_node.ready, !i_box.ready, "box taken during output stall")
    `OBP_ASSERT_NOW(a_level_cap, i_clk, i_rst_n, o_node.valid, w_item[MAX_LEVELS].level <= w_ctrl.depth, "level beyond max depth")
    `OBP_ASSERT_NOW(a_root_cell, i_clk, i_rst_n, o_node.valid && (w_item[MAX_LEVELS].level == '0), (o_node.cell_x == '0) && (o_node.cell_y == '0) && (o_node.cell_z == '0), "root word with nonzero cell")

endmodule
